>>> rtl/core/csvt_pkg.sv
// Shared types and codes for the CSV tokenizer.
`default_nettype none
package csvt_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_lex_state;

    typedef struct packed {
        logic  mode;
        t_byte data_byte;
    } t_in_item;

    // input modes
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // lexer states
    localparam t_lex_state LS_UNQUOTED   = 2'd0;
    localparam t_lex_state LS_QUOTED     = 2'd1;
    localparam t_lex_state LS_ESCAPE     = 2'd2;
    localparam t_lex_state LS_QUOTE_SEEN = 2'd3;

    // token kinds
    localparam t_kind TK_CHAR       = 3'd0;
    localparam t_kind TK_CELL_END   = 3'd1;
    localparam t_kind TK_ROW_END    = 3'd2;
    localparam t_kind TK_ERR_ESCAPE = 3'd3;
    localparam t_kind TK_ERR_QUOTE  = 3'd4;

    // characters
    localparam t_byte CH_COMMA     = 8'h2C;
    localparam t_byte CH_LF        = 8'h0A;
    localparam t_byte CH_CR        = 8'h0D;
    localparam t_byte CH_TAB       = 8'h09;
    localparam t_byte CH_DQUOTE    = 8'h22;
    localparam t_byte CH_BACKSLASH = 8'h5C;
    localparam t_byte CH_N         = 8'h6E;
    localparam t_byte CH_R         = 8'h72;
    localparam t_byte CH_T         = 8'h74;

endpackage
`default_nettype wire

>>> rtl/core/csvt_if.sv
// Valid/ready channel interfaces for text bytes in and tokens out.
`default_nettype none
interface csvt_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    csvt_pkg::t_byte    data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface csvt_out_if;
    logic               valid;
    logic               ready;
    csvt_pkg::t_kind    token_kind;
    csvt_pkg::t_byte    char_value;

    modport source (output valid, output token_kind, output char_value, input ready);
    modport sink   (input valid, input token_kind, input char_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/csvt_in_reg.sv
// Input register stage: holds one request; upstream ready is high while it is empty or downstream is ready.
`default_nettype none
module csvt_in_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_up_valid,
    output logic                    o_up_ready,
    input  wire csvt_pkg::t_in_item i_up_item,
    output logic                    o_dn_valid,
    input  wire logic               i_dn_ready,
    output csvt_pkg::t_in_item      o_dn_item
);
    import csvt_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_up_ready = !r_valid || i_dn_ready;
    assign o_dn_valid = r_valid;
    assign o_dn_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_up_valid && o_up_ready) begin
            r_item <= i_up_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/csvt_lexer.sv
// Lexer state, token decode and the result register.
`default_nettype none
module csvt_lexer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire csvt_pkg::t_in_item i_item,
    output logic                    o_tok_valid,
    input  wire logic               i_tok_ready,
    output csvt_pkg::t_kind         o_token_kind,
    output csvt_pkg::t_byte         o_char_value
);
    import csvt_pkg::*;

    t_lex_state r_st;
    logic       r_cell;
    logic       r_row;
    logic       r_tok_valid;
    t_kind      r_kind;
    t_byte      r_value;

    t_lex_state n_st;
    logic       n_cell;
    logic       n_row;
    logic       n_emit;
    t_kind      n_kind;
    t_byte      n_value;

    logic       take;

    assign o_ready      = !r_tok_valid || i_tok_ready;
    assign take         = i_valid && o_ready;
    assign o_tok_valid  = r_tok_valid;
    assign o_token_kind = r_kind;
    assign o_char_value = r_value;

    always_comb begin
        logic  unq;
        t_byte b;
        unq     = 1'b0;
        b       = i_item.data_byte;
        n_st    = r_st;
        n_cell  = r_cell;
        n_row   = r_row;
        n_emit  = 1'b0;
        n_kind  = TK_CHAR;
        n_value = '0;
        if (i_item.mode == MODE_END) begin
            n_st   = LS_UNQUOTED;
            n_cell = 1'b0;
            n_row  = 1'b0;
            if (r_st == LS_ESCAPE) begin
                n_emit = 1'b1;
                n_kind = TK_ERR_ESCAPE;
            end else if (r_st == LS_QUOTED) begin
                n_emit = 1'b1;
                n_kind = TK_ERR_QUOTE;
            end else if (r_cell || r_row) begin
                n_emit = 1'b1;
                n_kind = TK_ROW_END;
            end
        end else begin
            case (r_st)
                LS_QUOTED: begin
                    if (b == CH_BACKSLASH) begin
                        n_st = LS_ESCAPE;
                    end else if (b == CH_DQUOTE) begin
                        n_st = LS_QUOTE_SEEN;
                    end else begin
                        n_cell  = 1'b1;
                        n_emit  = 1'b1;
                        n_value = b;
                    end
                end
                LS_ESCAPE: begin
                    n_st    = LS_QUOTED;
                    n_cell  = 1'b1;
                    n_emit  = 1'b1;
                    if (b == CH_N) begin
                        n_value = CH_LF;
                    end else if (b == CH_R) begin
                        n_value = CH_CR;
                    end else if (b == CH_T) begin
                        n_value = CH_TAB;
                    end else begin
                        n_value = b;
                    end
                end
                LS_QUOTE_SEEN: begin
                    // doubled quote stays in the run; anything else closes it
                    if (b == CH_DQUOTE) begin
                        n_st    = LS_QUOTED;
                        n_cell  = 1'b1;
                        n_emit  = 1'b1;
                        n_value = CH_DQUOTE;
                    end else begin
                        unq = 1'b1;
                    end
                end
                default: begin
                    unq = 1'b1;
                end
            endcase
            if (unq) begin
                n_st = LS_UNQUOTED;
                if (b == CH_COMMA) begin
                    n_cell = 1'b0;
                    n_row  = 1'b1;
                    n_emit = 1'b1;
                    n_kind = TK_CELL_END;
                end else if (b == CH_LF) begin
                    n_cell = 1'b0;
                    n_row  = 1'b0;
                    n_emit = 1'b1;
                    n_kind = TK_ROW_END;
                end else if (b == CH_CR) begin
                    n_emit = 1'b0;
                end else if (b == CH_DQUOTE) begin
                    n_st = LS_QUOTED;
                end else begin
                    n_cell  = 1'b1;
                    n_emit  = 1'b1;
                    n_value = b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= LS_UNQUOTED;
            r_cell      <= 1'b0;
            r_row       <= 1'b0;
            r_tok_valid <= 1'b0;
        end else if (take) begin
            r_st        <= n_st;
            r_cell      <= n_cell;
            r_row       <= n_row;
            r_tok_valid <= n_emit;
        end else if (i_tok_ready) begin
            r_tok_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && n_emit) begin
            r_kind  <= n_kind;
            r_value <= n_value;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/csv_tokenizer_unit.sv
// Top level of the CSV tokenizer.
// The block takes one text byte or end-of-input request per cycle and gives
// at most one token per request. A request passes an input register, is
// decoded combinationally against the lexer state and lands in the result
// register, from which its token is presented. Sustained rate is one request
// per clock while the token output is not stalled, set by the lexer state
// update; a stalled token output holds both stages and then the input.
// Bytes inside a quoted run that close it are resolved when the next byte or
// end of input arrives. Error tokens (unfinished escape, unfinished quote)
// carry a char_value of zero and return the lexer to its start state.
`default_nettype none
module csv_tokenizer_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    csvt_in_if.sink     i_in,
    csvt_out_if.source  o_out
);
    import csvt_pkg::*;

    t_in_item up_item;
    t_in_item dn_item;
    logic     dn_valid;
    logic     dn_ready;

    assign up_item.mode      = i_in.mode;
    assign up_item.data_byte = i_in.data_byte;

    csvt_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (i_in.valid),
        .o_up_ready (i_in.ready),
        .i_up_item  (up_item),
        .o_dn_valid (dn_valid),
        .i_dn_ready (dn_ready),
        .o_dn_item  (dn_item)
    );

    csvt_lexer u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (dn_valid),
        .o_ready      (dn_ready),
        .i_item       (dn_item),
        .o_tok_valid  (o_out.valid),
        .i_tok_ready  (o_out.ready),
        .o_token_kind (o_out.token_kind),
        .o_char_value (o_out.char_value)
    );

endmodule
`default_nettype wire

>>> rtl/core/csvt_checker.sv
// Port-level checks for the CSV tokenizer, bound to the top level.
`default_nettype none
module csvt_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire csvt_pkg::t_kind i_token_kind,
    input wire csvt_pkg::t_byte i_char_value
);
    import csvt_pkg::*;

    // a stalled token keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_token_kind)
            && $stable(i_char_value))
        else $error("token changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_token_kind == TK_CHAR || i_token_kind == TK_CELL_END
            || i_token_kind == TK_ROW_END || i_token_kind == TK_ERR_ESCAPE
            || i_token_kind == TK_ERR_QUOTE))
        else $error("token kind out of range");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_token_kind != TK_CHAR |-> i_char_value == '0)
        else $error("non-char token carries a byte");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("token valid after reset");

    // a free-flowing output with nothing stalled accepts input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && $past(!i_out_valid) && $past(i_rst_n) |-> i_in_ready)
        else $error("input stalled with idle output");

endmodule

bind csv_tokenizer_unit csvt_checker u_csvt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_token_kind (o_out.token_kind),
    .i_char_value (o_out.char_value)
);
`default_nettype wire

>>> test/csv_tokenizer_unit_test.sv
// Self-checking testbench for the CSV tokenizer: directed table, then random CSV text.
`default_nettype none
module csv_tokenizer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csvt_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 1700;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        t_kind kind;
        t_byte ch;
    } t_token;

    typedef struct {
        logic   mode;
        t_byte  data;
        bit     typed;
        bit     has_tok;
        t_token tok;
    } t_dir_row;

    logic clk;
    logic rst_n;

    csvt_in_if  in_ch ();
    csvt_out_if out_ch ();

    csv_tokenizer_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state
    t_lex_state lex_st;
    bit         cell_open;
    bit         row_open;

    t_token   pending_tokens [$];
    t_dir_row dir_rows [$];

    // sideband for the request currently offered
    bit     drv_typed;
    bit     drv_has;
    t_token drv_tok;

    int  fail_count;
    int  sent_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off_req;

    initial begin
        clk = 1'b0;
    end

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit unquoted_token(input t_byte b, output t_token tok);
        tok    = '0;
        lex_st = LS_UNQUOTED;
        if (b == CH_COMMA) begin
            cell_open = 1'b0;
            row_open  = 1'b1;
            tok.kind  = TK_CELL_END;
            return 1'b1;
        end
        if (b == CH_LF) begin
            cell_open = 1'b0;
            row_open  = 1'b0;
            tok.kind  = TK_ROW_END;
            return 1'b1;
        end
        if (b == CH_CR)
            return 1'b0;
        if (b == CH_DQUOTE) begin
            lex_st = LS_QUOTED;
            return 1'b0;
        end
        cell_open = 1'b1;
        tok.kind  = TK_CHAR;
        tok.ch    = b;
        return 1'b1;
    endfunction

    function automatic bit lex_next_token(input logic mode, input t_byte b, output t_token tok);
        bit    hit;
        t_byte c;
        tok = '0;
        c   = b;
        hit = 1'b1;
        if (mode == MODE_END) begin
            if (lex_st == LS_ESCAPE)
                tok.kind = TK_ERR_ESCAPE;
            else if (lex_st == LS_QUOTED)
                tok.kind = TK_ERR_QUOTE;
            else if (cell_open || row_open)
                tok.kind = TK_ROW_END;
            else
                hit = 1'b0;
            lex_st    = LS_UNQUOTED;
            cell_open = 1'b0;
            row_open  = 1'b0;
            return hit;
        end
        case (lex_st)
            LS_QUOTED: begin
                if (b == CH_BACKSLASH) begin
                    lex_st = LS_ESCAPE;
                    return 1'b0;
                end
                if (b == CH_DQUOTE) begin
                    lex_st = LS_QUOTE_SEEN;
                    return 1'b0;
                end
                cell_open = 1'b1;
                tok.kind  = TK_CHAR;
                tok.ch    = b;
                return 1'b1;
            end
            LS_ESCAPE: begin
                if (b == CH_N)
                    c = CH_LF;
                else if (b == CH_R)
                    c = CH_CR;
                else if (b == CH_T)
                    c = CH_TAB;
                lex_st    = LS_QUOTED;
                cell_open = 1'b1;
                tok.kind  = TK_CHAR;
                tok.ch    = c;
                return 1'b1;
            end
            LS_QUOTE_SEEN: begin
                // doubled quote stays in the run, anything else closes it
                if (b == CH_DQUOTE) begin
                    lex_st    = LS_QUOTED;
                    cell_open = 1'b1;
                    tok.kind  = TK_CHAR;
                    tok.ch    = CH_DQUOTE;
                    return 1'b1;
                end
                return unquoted_token(b, tok);
            end
            default: begin
                return unquoted_token(b, tok);
            end
        endcase
    endfunction

    function automatic void report_fail(input string what, input t_token want, input t_token got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s: expected kind %0d char %02h, got kind %0d char %02h",
                     $realtime, what, want.kind, want.ch, got.kind, got.ch);
    endfunction

    function automatic void add_row(input logic mode, input t_byte data, input bit typed,
                                    input bit has_tok, input t_kind kind, input t_byte ch);
        t_dir_row row;
        row.mode     = mode;
        row.data     = data;
        row.typed    = typed;
        row.has_tok  = has_tok;
        row.tok.kind = kind;
        row.tok.ch   = ch;
        dir_rows     = {dir_rows, row};
    endfunction

    function automatic t_byte pick_special();
        case ($urandom_range(8))
            0:       return CH_COMMA;
            1:       return CH_LF;
            2:       return CH_CR;
            3:       return CH_DQUOTE;
            4:       return CH_BACKSLASH;
            5:       return CH_N;
            6:       return CH_R;
            7:       return CH_T;
            default: return t_byte'($urandom_range(255));
        endcase
    endfunction

    task automatic send_req(input logic mode, input t_byte data, input bit typed,
                            input bit has_tok, input t_token tok);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.data_byte <= data;
        drv_typed       <= typed;
        drv_has         <= has_tok;
        drv_tok         <= tok;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_byte(input t_byte data);
        send_req(MODE_DATA, data, 1'b0, 1'b0, '0);
    endtask

    task automatic send_end();
        send_req(MODE_END, t_byte'($urandom_range(255)), 1'b0, 1'b0, '0);
    endtask

    // scoreboard: predict on accepted requests, compare on accepted tokens
    always @(posedge clk) begin : scoreboard
        t_token pred;
        t_token got;
        t_token want;
        bit     hit;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.kind = out_ch.token_kind;
                got.ch   = out_ch.char_value;
                if (pending_tokens.size() == 0) begin
                    report_fail("unexpected token", '0, got);
                end else begin
                    want = pending_tokens.pop_front();
                    if (got.kind !== want.kind || got.ch !== want.ch)
                        report_fail("token mismatch", want, got);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                hit = lex_next_token(in_ch.mode, in_ch.data_byte, pred);
                if (drv_typed) begin
                    if (drv_has)
                        pending_tokens = {pending_tokens, drv_tok};
                end else if (hit) begin
                    pending_tokens = {pending_tokens, pred};
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL csv_tokenizer_unit");
        $finish;
    end

    initial begin : token_sink
        int hold;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req && rst_n) begin
                // long back-pressure: the block fills and stalls its input
                out_ch.ready <= 1'b0;
                for (hold = 1; hold < HOLD_OFF_CYCLES; hold++)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int k;
        int n;
        int sel;
        int phase;
        int phase_end;
        t_byte sep;
        t_dir_row row;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_DATA;
        in_ch.data_byte <= '0;
        drv_typed       <= 1'b0;
        drv_has         <= 1'b0;
        drv_tok         <= '0;
        lex_st          = LS_UNQUOTED;
        cell_open       = 1'b0;
        row_open        = 1'b0;
        fail_count      = 0;
        sent_count      = 0;
        hold_off_req    = 1'b0;
        send_idle_pct   = 10;
        recv_idle_pct   = 84;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // end of input right after reset gives nothing
        add_row(MODE_END,  8'h00,        1, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, 8'h00,        1, 1, TK_CHAR,       8'h00);
        add_row(MODE_DATA, 8'hFF,        1, 1, TK_CHAR,       8'hFF);
        add_row(MODE_DATA, CH_COMMA,     1, 1, TK_CELL_END,   8'h00);
        add_row(MODE_DATA, CH_CR,        1, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_LF,        1, 1, TK_ROW_END,    8'h00);
        // escapes inside a quoted run
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_BACKSLASH, 0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_N,         0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_BACKSLASH, 0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_T,         0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_BACKSLASH, 0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_R,         0, 0, TK_CHAR,       8'h00);
        // doubled quote, then close by a comma
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_COMMA,     0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_LF,        0, 0, TK_CHAR,       8'h00);
        // empty quoted run at end of text
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_END,  8'hA5,        0, 0, TK_CHAR,       8'h00);
        // end right after a closing quote
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, 8'h78,        0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_END,  8'h5A,        0, 0, TK_CHAR,       8'h00);
        // unfinished escape and unfinished quote
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_BACKSLASH, 0, 0, TK_CHAR,       8'h00);
        add_row(MODE_END,  8'hFF,        1, 1, TK_ERR_ESCAPE, 8'h00);
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_END,  8'h00,        1, 1, TK_ERR_QUOTE,  8'h00);
        // closing quote followed by a plain byte
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, CH_DQUOTE,    0, 0, TK_CHAR,       8'h00);
        add_row(MODE_DATA, 8'h7A,        0, 0, TK_CHAR,       8'h00);
        add_row(MODE_END,  8'h00,        0, 0, TK_CHAR,       8'h00);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send_req(row.mode, row.data, row.typed, row.has_tok, row.tok);
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 10;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_off_req  = 1'b1;
                end
            endcase
            phase_end = sent_count + RANDOM_ITEMS / 3;
            while (sent_count < phase_end) begin
                sel = $urandom_range(99);
                if (sel < 8) begin
                    // noise: loose specials, random bytes, stray ends
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++) begin
                        if ($urandom_range(3) == 0)
                            send_end();
                        else
                            send_byte(pick_special());
                    end
                end else begin
                    if (sel < 55) begin
                        send_byte(CH_DQUOTE);
                        n = $urandom_range(0, 6);
                        for (k = 0; k < n; k++) begin
                            sel = $urandom_range(99);
                            if (sel < 65) begin
                                send_byte(t_byte'($urandom_range(255)));
                            end else if (sel < 85) begin
                                send_byte(CH_BACKSLASH);
                                case ($urandom_range(3))
                                    0:       send_byte(CH_N);
                                    1:       send_byte(CH_R);
                                    2:       send_byte(CH_T);
                                    default: send_byte(t_byte'($urandom_range(255)));
                                endcase
                            end else begin
                                send_byte(CH_DQUOTE);
                                send_byte(CH_DQUOTE);
                            end
                        end
                        // a few runs are left open on purpose
                        if ($urandom_range(19) != 0)
                            send_byte(CH_DQUOTE);
                    end else begin
                        n = $urandom_range(0, 6);
                        for (k = 0; k < n; k++)
                            send_byte(t_byte'($urandom_range(255)));
                    end
                    sel = $urandom_range(99);
                    if (sel < 50) begin
                        send_byte(CH_COMMA);
                    end else if (sel < 75) begin
                        send_byte(CH_LF);
                    end else if (sel < 85) begin
                        send_byte(CH_CR);
                        send_byte(CH_LF);
                    end else if (sel < 93) begin
                        send_end();
                    end else begin
                        sep = pick_special();
                        send_byte(sep);
                    end
                end
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (pending_tokens.size() != 0)
            report_fail("token never arrived", pending_tokens[0], '0);

        if (fail_count == 0) begin
            $display("PASS csv_tokenizer_unit");
        end else begin
            $display("FAIL csv_tokenizer_unit");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
rtl/core/csvt_pkg.sv
rtl/core/csvt_if.sv
rtl/core/csvt_in_reg.sv
rtl/core/csvt_lexer.sv
rtl/core/csv_tokenizer_unit.sv
rtl/core/csvt_checker.sv
test/csv_tokenizer_unit_test.sv
